### src/ssf_pkg.sv
package ssf_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MODE_W   = 2;
	localparam int WINDOW_W = 7;
	localparam int WEIGHT_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [MODE_W-1:0]    mode_t;

	// register indexes
	localparam cfg_idx_t REG_MODE   = 2'd0;
	localparam cfg_idx_t REG_WINDOW = 2'd1;
	localparam cfg_idx_t REG_WEIGHT = 2'd2;

	// filter modes
	localparam mode_t MODE_AVG  = 2'd0;
	localparam mode_t MODE_EXP  = 2'd1;
	localparam mode_t MODE_DIFF = 2'd2;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd32;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd16384;

	// Q1.15 smoothing weight
	localparam int COEF_W    = 17;
	localparam int FRAC_BITS = 15;
	localparam logic [COEF_W-1:0] ONE_Q15 = 17'd32768;

	// headroom bits on the running sum beyond one full window
	localparam int SUM_GUARD = 4;

endpackage

### src/ssf_div.sv
module ssf_div #(
	parameter int SUM_W = 26,
	parameter int DIV_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic        [DIV_W-1:0] divisor,
	output logic                    done,
	output logic signed [SUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W-1:0] rem_q;
	logic [SUM_W-1:0] mag_q;
	logic signed [SUM_W-1:0] quo_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] trial_sub;
	logic           fits;

	// restoring division on the magnitude, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, mag_q[SUM_W-1]};
		trial_sub = trial - {1'b0, d_q};
		fits      = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
				mag_q <= {mag_q[SUM_W-2:0], fits};
			end else begin
				// truncate toward zero: sign applied to the magnitude quotient
				quo_q <= neg_q ? -$signed(mag_q) : $signed(mag_q);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### src/segment_smoothing_filter.sv
// Channel   Valid          Stall          Payload
// input     sample_valid   sample_stall   sample, segment_start, segment_end
// result    result_valid   result_stall   filtered, final_res
// config    cfg_write      -              cfg_index, cfg_data
//
// One request at a time. Difference and smoothing: ST_ADD, ST_MUL1, ST_MUL2
// and ST_MACC, set by the shared Q1.15 multiplier (two products, one
// accumulate). Moving average: ST_DIV waits on the serial divider of the
// running sum, then one result per cycle while result_stall is low, up to
// window on the segment's last sample. sample_stall is high from accept until
// the return to ST_IDLE. Reset is asynchronous and needs no clearing pass; the
// delay line is read only at entries written in the current segment.
module segment_smoothing_filter #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ssf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            segment_start,
	input  logic                            segment_end,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [SAMPLE_BITS:0]     filtered,
	output logic                            final_res
);

	import ssf_pkg::*;

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int IDX_W  = PTR_W + 1;
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + PTR_W + SUM_GUARD;
	localparam int OUT_W  = SAMPLE_BITS + 1;
	localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
	localparam int ACC_W  = PROD_W + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_MACC = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	// configuration
	mode_t                mode_q;
	logic [WINDOW_W-1:0]  window_q;
	logic [WEIGHT_W-1:0]  weight_q;

	// control and filter state
	logic [2:0]                    state_q;
	logic [PTR_W-1:0]              wp_q;
	logic [WIN_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] smooth_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          first_q;
	logic                          end_q;
	logic [WIN_W-1:0]              copies_q;

	// datapath payload
	logic [SAMPLE_BITS-1:0]        dl_mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0]        rd_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [OUT_W-1:0]       diff_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [OUT_W-1:0]       filtered_q;

	// combinational
	logic [WIN_W-1:0]              w_eff;
	logic [COEF_W-1:0]             a_eff;
	logic [COEF_W-1:0]             a_rest;
	logic [IDX_W-1:0]              idx_sum;
	logic [PTR_W-1:0]              rd_idx;
	logic                          window_full;
	logic [COEF_W-1:0]             mul_coef;
	logic signed [SAMPLE_BITS-1:0] mul_in;
	logic signed [PROD_W-1:0]      mul_prod;
	logic signed [ACC_W-1:0]       acc_sum;
	logic signed [SAMPLE_BITS-1:0] smooth_next;
	logic signed [SUM_W-1:0]       x_ext;
	logic signed [SUM_W-1:0]       rd_ext;
	logic                          div_start;
	logic                          div_done;
	logic signed [SUM_W-1:0]       div_quo;

	// window clamped to 1..MAX_WINDOW, weight clamped to 1.0
	always_comb begin
		if (32'(window_q) > MAX_WINDOW) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else if (window_q == '0) begin
			w_eff = WIN_W'(1);
		end else begin
			w_eff = WIN_W'(window_q);
		end
		a_eff  = (COEF_W'(weight_q) > ONE_Q15) ? ONE_Q15 : COEF_W'(weight_q);
		a_rest = ONE_Q15 - a_eff;
	end

	// oldest sample of the window sits w entries behind the write pointer
	always_comb begin
		idx_sum = IDX_W'(wp_q) + IDX_W'(MAX_WINDOW) - IDX_W'(w_eff);
		if (idx_sum >= IDX_W'(MAX_WINDOW)) begin
			rd_idx = PTR_W'(idx_sum - IDX_W'(MAX_WINDOW));
		end else begin
			rd_idx = PTR_W'(idx_sum);
		end
	end

	assign window_full = fill_q >= w_eff;
	assign x_ext       = SUM_W'(x_q);
	assign rd_ext      = SUM_W'($signed(rd_q));

	// shared multiplier: (1 - alpha) * y first, then alpha * x
	always_comb begin
		mul_coef = (state_q == ST_MUL1) ? a_rest : a_eff;
		mul_in   = (state_q == ST_MUL1) ? smooth_q : x_q;
		mul_prod = $signed({1'b0, mul_coef}) * mul_in;
		acc_sum  = acc_q + ACC_W'(prod_q);
		// floor shift by 15 is the bit slice above the fraction
		smooth_next = first_q ? '0 : acc_sum[FRAC_BITS +: SAMPLE_BITS];
	end

	assign div_start = (state_q == ST_MACC) && (mode_q == MODE_AVG) && window_full;

	ssf_div #(
		.SUM_W(SUM_W),
		.DIV_W(WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (w_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_AVG;
			window_q <= WINDOW_RESET;
			weight_q <= WEIGHT_RESET;
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			smooth_q <= '0;
			prev_q   <= '0;
			first_q  <= 1'b0;
			end_q    <= 1'b0;
			copies_q <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
					REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
					REG_WEIGHT: weight_q <= cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						end_q   <= segment_end;
						first_q <= segment_start || (fill_q == '0);
						if (segment_start) begin
							fill_q   <= '0;
							sum_q    <= '0;
							smooth_q <= '0;
							prev_q   <= '0;
						end
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					// drop the oldest sample once the window is full
					if (window_full) begin
						sum_q <= sum_q - rd_ext + x_ext;
					end else begin
						sum_q <= sum_q + x_ext;
					end
					wp_q    <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
					fill_q  <= (fill_q == WIN_W'(MAX_WINDOW)) ? fill_q : fill_q + 1'b1;
					prev_q  <= x_q;
					state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MACC;
				ST_MACC: begin
					// a cleared segment restarts with first set, so the smoothed
					// value need not be zeroed here
					smooth_q <= smooth_next;
					case (mode_q)
						MODE_AVG: begin
							if (window_full) begin
								state_q <= ST_DIV;
							end else begin
								// short window: nothing out, segment may still close
								state_q <= ST_IDLE;
								if (end_q) begin
									fill_q <= '0;
									sum_q  <= '0;
									prev_q <= '0;
								end
							end
						end
						MODE_EXP, MODE_DIFF: begin
							copies_q <= WIN_W'(1);
							state_q  <= ST_EMIT;
						end
						default: begin
							// unused mode: state updated, no result
							state_q <= ST_IDLE;
							if (end_q) begin
								fill_q <= '0;
								sum_q  <= '0;
								prev_q <= '0;
							end
						end
					endcase
				end
				ST_DIV: begin
					if (div_done) begin
						// segment end repeats the average to fill out the window
						copies_q <= end_q ? w_eff : WIN_W'(1);
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!result_stall) begin
						if (copies_q == WIN_W'(1)) begin
							state_q <= ST_IDLE;
							if (end_q) begin
								fill_q   <= '0;
								sum_q    <= '0;
								smooth_q <= '0;
								prev_q   <= '0;
							end
						end else begin
							copies_q <= copies_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// delay line and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			rd_q <= dl_mem[rd_idx];
			x_q  <= sample;
		end
		if (state_q == ST_ADD) begin
			dl_mem[wp_q] <= x_q;
			diff_q       <= first_q ? '0 : OUT_W'(x_q) - OUT_W'(prev_q);
		end
		if (state_q == ST_MUL1) begin
			prod_q <= mul_prod;
		end
		if (state_q == ST_MUL2) begin
			acc_q  <= ACC_W'(prod_q);
			prod_q <= mul_prod;
		end
		if (state_q == ST_MACC) begin
			if (mode_q == MODE_EXP) begin
				filtered_q <= OUT_W'(smooth_next);
			end else begin
				filtered_q <= diff_q;
			end
		end
		if ((state_q == ST_DIV) && div_done) begin
			filtered_q <= div_quo[OUT_W-1:0];
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_EMIT);
	assign filtered     = filtered_q;
	assign final_res    = end_q && (copies_q == WIN_W'(1));

	// no result can appear in the cycle right after a request is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> !result_valid)
		else $error("result raised right after accept");

	// fill count saturates at the delay line depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_W'(MAX_WINDOW))
		else $error("fill count above depth");

	// divider finishes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside wait state");

	// repeat count stays within the window while results go out
	a_copies_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (copies_q != '0) && (copies_q <= w_eff))
		else $error("result repeat count out of range");

endmodule
